// ----- hdl/cob_pkg.sv -----
// ----------------------------------------------------------------------------
// Coverage-over blend package
// Shared widths, pipeline depths, pixel types and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package cob_pkg;

  localparam int CHAN_W = 8;
  localparam logic [CHAN_W-1:0] FULL = 8'd255;

  // Command codes carried on the command input.
  localparam logic CMD_BLEND         = 1'b0;
  localparam logic CMD_UNPREMULTIPLY = 1'b1;

  // The unpremultiply divider retires one quotient bit per stage.
  localparam int DIV_STEPS = CHAN_W;
  // Both units are register stages deep by this amount.
  localparam int PIPE_DEPTH = DIV_STEPS + 1;
  // Stages of real work in the blend unit; the rest is a delay line.
  localparam int BLEND_STAGES = 6;
  // Start to result strobe, counting the output register.
  localparam int OUT_LATENCY = PIPE_DEPTH + 1;

  // Colour channels: index 2 is red, 1 is green, 0 is blue.
  typedef logic [2:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    rgb_t              color;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  // Floor of x / 255 for x up to 255 * 255, by the add-and-shift identity.
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
    logic [2*CHAN_W:0] t;
    t = {1'b0, x} + (2*CHAN_W+1)'(1) + {{(CHAN_W+1){1'b0}}, x[2*CHAN_W-1:CHAN_W]};
    return t[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

// ----- hdl/cob_blend.sv -----
// ----------------------------------------------------------------------------
// Coverage-over blend unit
// Pipelined "over" operator of a coloured run onto a premultiplied pixel.
// ----------------------------------------------------------------------------
module cob_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      coverage,
  input  logic [7:0]      run_transparency,
  input  cob_pkg::rgb_t   run,
  input  cob_pkg::pixel_t dst,
  output logic            out_valid,
  output cob_pkg::pixel_t out_pix
);
  import cob_pkg::*;

  localparam int TAIL = PIPE_DEPTH - BLEND_STAGES;

  typedef logic [2:0][2*CHAN_W-1:0] rgb_wide_t;

  logic [CHAN_W-1:0]   opacity;
  logic [CHAN_W-1:0]   keep;

  logic                v1, v2, v3, v4, v5;
  rgb_t                src1, src2;
  pixel_t              dst1, dst2, dst3, dst4, dst5;
  logic [2*CHAN_W-1:0] cov_prod1;
  logic                opq_zero1, opq_zero2;
  logic [CHAN_W-1:0]   k2, k3, k4, k5;
  rgb_wide_t           mix_src3, mix_dst3, sum4;
  logic [2*CHAN_W-1:0] a_prod3, a_prod4;
  logic                pass3, pass4, pass5;
  rgb_t                q5;
  logic [CHAN_W-1:0]   qa5;
  logic                vd  [TAIL+1];
  pixel_t              dly [TAIL+1];

  assign opacity = FULL - run_transparency;
  assign keep    = FULL - k2;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      vd[0] <= 1'b0;
    end else begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      vd[0] <= v5;
    end
  end

  // Stage 1: coverage times opacity.
  always_ff @(posedge clk) begin
    src1      <= run;
    dst1      <= dst;
    cov_prod1 <= {{CHAN_W{1'b0}}, coverage} * {{CHAN_W{1'b0}}, opacity};
    opq_zero1 <= (run_transparency == FULL);
  end

  // Stage 2: scale the product back to a weight k.
  always_ff @(posedge clk) begin
    src2      <= src1;
    dst2      <= dst1;
    k2        <= div255(cov_prod1);
    opq_zero2 <= opq_zero1;
  end

  // Stage 3: weight the run colour by k and the destination by 255 - k.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      mix_src3[ch] <= {{CHAN_W{1'b0}}, src2[ch]} * {{CHAN_W{1'b0}}, k2};
      mix_dst3[ch] <= {{CHAN_W{1'b0}}, dst2.color[ch]} * {{CHAN_W{1'b0}}, keep};
    end
    a_prod3 <= {{CHAN_W{1'b0}}, dst2.alpha} * {{CHAN_W{1'b0}}, keep};
    k3      <= k2;
    pass3   <= opq_zero2 || (k2 == '0);
    dst3    <= dst2;
  end

  // Stage 4: sum the two weighted terms of each colour.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      sum4[ch] <= mix_src3[ch] + mix_dst3[ch];
    end
    a_prod4 <= a_prod3;
    k4      <= k3;
    pass4   <= pass3;
    dst4    <= dst3;
  end

  // Stage 5: divide every term by 255.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      q5[ch] <= div255(sum4[ch]);
    end
    qa5   <= div255(a_prod4);
    k5    <= k4;
    pass5 <= pass4;
    dst5  <= dst4;
  end

  // Stage 6: blend, or an invisible run leaves the destination untouched.
  always_ff @(posedge clk) begin
    if (pass5) begin
      dly[0] <= dst5;
    end else begin
      dly[0].color <= q5;
      dly[0].alpha <= k5 + qa5;
    end
  end

  // Delay line that matches the depth of the unpremultiply unit.
  for (genvar i = 1; i <= TAIL; i++) begin : g_tail
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[i] <= 1'b0;
      end else begin
        vd[i] <= vd[i-1];
      end
    end

    always_ff @(posedge clk) begin
      dly[i] <= dly[i-1];
    end
  end

  assign out_valid = vd[TAIL];
  assign out_pix   = dly[TAIL];

endmodule

// ----- hdl/cob_unpremul.sv -----
// ----------------------------------------------------------------------------
// Coverage-over unpremultiply unit
// Pipelined restoring divider giving min(255, c * 255 / alpha) per channel.
// ----------------------------------------------------------------------------
module cob_unpremul (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  cob_pkg::pixel_t dst,
  output logic            out_valid,
  output cob_pkg::pixel_t out_pix
);
  import cob_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W-1:0] q;
    logic              sat;
    logic [CHAN_W-1:0] c;
  } div_lane_t;

  logic [2*CHAN_W-1:0] num [3];
  div_lane_t           lane [DIV_STEPS+1][3];
  logic                vld  [DIV_STEPS+1];
  logic [CHAN_W-1:0]   alp  [DIV_STEPS+1];
  logic                pass [DIV_STEPS+1];

  // Dividend c * 255 formed as c * 256 - c.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num[ch] = {dst.color[ch], {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, dst.color[ch]};
    end
  end

  // Stage 1: load the divider. A channel at or above its alpha saturates,
  // otherwise the quotient fits in one byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      lane[0][ch].rem <= num[ch][2*CHAN_W-1:CHAN_W];
      lane[0][ch].lo  <= num[ch][CHAN_W-1:0];
      lane[0][ch].q   <= '0;
      lane[0][ch].sat <= (dst.color[ch] >= dst.alpha);
      lane[0][ch].c   <= dst.color[ch];
    end
    alp[0]  <= dst.alpha;
    pass[0] <= (dst.alpha == '0) || (dst.alpha == FULL);
  end

  // One quotient bit per stage.
  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    logic [CHAN_W:0] trial [3];
    logic            take  [3];

    always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
        trial[ch] = {lane[s-1][ch].rem, lane[s-1][ch].lo[CHAN_W-1]};
        take[ch]  = (trial[ch] >= {1'b0, alp[s-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (take[ch]) begin
          lane[s][ch].rem <= CHAN_W'(trial[ch] - {1'b0, alp[s-1]});
        end else begin
          lane[s][ch].rem <= trial[ch][CHAN_W-1:0];
        end
        lane[s][ch].lo  <= {lane[s-1][ch].lo[CHAN_W-2:0], 1'b0};
        lane[s][ch].q   <= {lane[s-1][ch].q[CHAN_W-2:0], take[ch]};
        lane[s][ch].sat <= lane[s-1][ch].sat;
        lane[s][ch].c   <= lane[s-1][ch].c;
      end
      alp[s]  <= alp[s-1];
      pass[s] <= pass[s-1];
    end
  end

  // Alpha zero or full passes the pixel; else saturate or take the quotient.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (pass[DIV_STEPS]) begin
        out_pix.color[ch] = lane[DIV_STEPS][ch].c;
      end else if (lane[DIV_STEPS][ch].sat) begin
        out_pix.color[ch] = FULL;
      end else begin
        out_pix.color[ch] = lane[DIV_STEPS][ch].q;
      end
    end
    out_pix.alpha = alp[DIV_STEPS];
  end

  assign out_valid = vld[DIV_STEPS];

endmodule

// ----- hdl/coverage_over_blend_pixel.sv -----
// done is registered from the valid of the unit that took the start transfer.
// Throughput: one pixel per cycle outside reset; the 8-stage divider sets the depth.
// busy is high only while rst is high; the result side cannot stall.
// Reset clears every valid bit in both units and the done strobe.
// ----------------------------------------------------------------------------
// Coverage-over blend pixel
// Per-pixel compositor: blends a run colour over a destination pixel under a
// coverage byte, or unpremultiplies a pixel, as the command selects.
// ----------------------------------------------------------------------------
module coverage_over_blend_pixel (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       command,
  input  logic [7:0] coverage,
  input  logic [7:0] run_red,
  input  logic [7:0] run_green,
  input  logic [7:0] run_blue,
  input  logic [7:0] run_transparency,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_alpha,
  output logic       done,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  import cob_pkg::*;

  logic   accept;
  rgb_t   run_pix;
  pixel_t dst_pix;
  logic   blend_valid, unp_valid;
  pixel_t blend_pix, unp_pix;
  pixel_t result;

  // Items are taken every cycle outside reset.
  assign busy    = rst;
  assign accept  = start && !busy;
  assign run_pix = {run_red, run_green, run_blue};
  assign dst_pix = '{color: {dst_red, dst_green, dst_blue}, alpha: dst_alpha};

  cob_blend u_blend (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (accept && (command == CMD_BLEND)),
    .coverage         (coverage),
    .run_transparency (run_transparency),
    .run              (run_pix),
    .dst              (dst_pix),
    .out_valid        (blend_valid),
    .out_pix          (blend_pix)
  );

  cob_unpremul u_unpremul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && (command == CMD_UNPREMULTIPLY)),
    .dst       (dst_pix),
    .out_valid (unp_valid),
    .out_pix   (unp_pix)
  );

  // Output register: take the result of whichever unit finished this item.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= blend_valid || unp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (unp_valid) begin
      result <= unp_pix;
    end else begin
      result <= blend_pix;
    end
  end

  assign out_red   = result.color[2];
  assign out_green = result.color[1];
  assign out_blue  = result.color[0];
  assign out_alpha = result.alpha;

  // Both units have equal depth, so at most one finishes in any cycle.
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({blend_valid, unp_valid}))
    else $error("both units delivered a result in the same cycle");

  // Every transfer in gives exactly one strobe a fixed time later.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##OUT_LATENCY done)
    else $error("result strobe missing after a start transfer");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, OUT_LATENCY))
    else $error("result strobe without a matching start transfer");

  // A fully transparent run leaves the destination alpha as it was.
  a_clear_run: assert property (@(posedge clk) disable iff (rst)
    accept && (command == CMD_BLEND) && (run_transparency == FULL)
      |-> ##OUT_LATENCY (out_alpha == $past(dst_alpha, OUT_LATENCY)))
    else $error("transparent run changed the destination alpha");

endmodule
